// ===== sv/trle_pkg.sv =====
`timescale 1ns / 1ps

package trle_pkg;

  localparam int unsigned CfgAddrWidth = 4;
  localparam int unsigned CfgDataWidth = 32;

  // register indexes on the configuration port
  localparam logic [1:0] REG_WIDTH  = 2'd0;
  localparam logic [1:0] REG_HEIGHT = 2'd1;
  localparam logic [1:0] REG_BITS   = 2'd2;

  localparam logic [15:0] WIDTH_RESET  = 16'd1;
  localparam logic [15:0] HEIGHT_RESET = 16'd1;
  localparam logic [7:0]  BITS_RESET   = 8'd24;

  localparam logic [7:0] RUN_HEADER_MIN = 8'd128;
  localparam logic [7:0] RUN_BIAS       = 8'd127;
  localparam logic [7:0] BITS_24        = 8'd24;
  localparam logic [7:0] BITS_32        = 8'd32;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_BAD_CFG  = 2'd1;
  localparam logic [1:0] ST_OVERFLOW = 2'd2;

  typedef enum logic [2:0] {
    PH_HEAD,
    PH_RAW,
    PH_RUN,
    PH_DONE,
    PH_ERR_CFG,
    PH_ERR_OVF
  } phase_t;

  // settings derived from the configuration registers
  typedef struct packed {
    logic        ok;       // size and depth supported
    logic        depth32;  // four bytes per pixel
    logic [31:0] total;    // width times height
  } cfg_t;

  typedef struct packed {
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
    logic [7:0]  alpha;
    logic [7:0]  run_length;
    logic [31:0] first_pixel;
    logic        image_done;
    logic [1:0]  status;
  } result_t;

endpackage

// ===== sv/trle_cfg.sv =====
`timescale 1ns / 1ps

module trle_cfg
  import trle_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    psel,
  input  logic                    penable,
  input  logic                    pwrite,
  input  logic [CfgAddrWidth-1:0] paddr,
  input  logic [CfgDataWidth-1:0] pwdata,
  output logic [CfgDataWidth-1:0] prdata,
  output cfg_t                    cfg
);

  logic [15:0] image_width, image_width_next;
  logic [15:0] image_height, image_height_next;
  logic [7:0]  pixel_bits, pixel_bits_next;
  logic [1:0]  reg_index;
  logic        wr_en;

  assign reg_index = paddr[3:2];
  assign wr_en     = psel && penable && pwrite;

  always_comb begin
    image_width_next  = image_width;
    image_height_next = image_height;
    pixel_bits_next   = pixel_bits;
    if (wr_en) begin
      unique case (reg_index)
        REG_WIDTH:  image_width_next  = pwdata[15:0];
        REG_HEIGHT: image_height_next = pwdata[15:0];
        REG_BITS:   pixel_bits_next   = pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_index)
      REG_WIDTH:  prdata = {16'd0, image_width};
      REG_HEIGHT: prdata = {16'd0, image_height};
      REG_BITS:   prdata = {24'd0, pixel_bits};
      default:    prdata = '0;
    endcase
  end

  // derived settings are registered with the write itself
  always_ff @(posedge clk) begin
    if (rst) begin
      image_width  <= WIDTH_RESET;
      image_height <= HEIGHT_RESET;
      pixel_bits   <= BITS_RESET;
      cfg.ok       <= 1'b1;
      cfg.depth32  <= 1'b0;
      cfg.total    <= 32'(WIDTH_RESET) * 32'(HEIGHT_RESET);
    end else begin
      image_width  <= image_width_next;
      image_height <= image_height_next;
      pixel_bits   <= pixel_bits_next;
      cfg.ok       <= (image_width_next != 16'd0) && (image_height_next != 16'd0) &&
                      ((pixel_bits_next == BITS_24) || (pixel_bits_next == BITS_32));
      cfg.depth32  <= (pixel_bits_next == BITS_32);
      cfg.total    <= 32'(image_width_next) * 32'(image_height_next);
    end
  end

endmodule

// ===== sv/trle_core.sv =====
`timescale 1ns / 1ps

module trle_core
  import trle_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       step,
  input  logic [7:0] data_byte,
  input  logic       frame_start,
  input  cfg_t       cfg,
  output logic       res_valid,
  output result_t    res
);

  phase_t      phase, phase_e, phase_next;
  logic [7:0]  packet_left, left_e, packet_left_next;
  logic [1:0]  byte_in_pixel, bip_e, byte_in_pixel_next;
  logic [31:0] colour_bytes, col_e, colour_bytes_next;
  logic [31:0] pixels_done, pd_e, pixels_done_next;

  logic [31:0] col_new;
  logic [2:0]  nbytes;
  logic        pix_full;
  logic        is_raw;
  logic [7:0]  run;
  logic [7:0]  left_after;
  logic [32:0] sum;
  logic        ovf;
  logic        done;

  // frame start clears the decoder before the byte is taken
  always_comb begin
    if (frame_start) begin
      phase_e = PH_HEAD;
      left_e  = '0;
      bip_e   = '0;
      col_e   = '0;
      pd_e    = '0;
    end else begin
      phase_e = phase;
      left_e  = packet_left;
      bip_e   = byte_in_pixel;
      col_e   = colour_bytes;
      pd_e    = pixels_done;
    end
  end

  always_comb begin
    nbytes     = cfg.depth32 ? 3'd4 : 3'd3;
    col_new    = col_e | (32'(data_byte) << {bip_e, 3'b000});
    pix_full   = ({1'b0, bip_e} + 3'd1) >= nbytes;
    is_raw     = (phase_e == PH_RAW);
    run        = is_raw ? 8'd1 : left_e;
    left_after = is_raw ? left_e - 8'd1 : 8'd0;
    sum        = {1'b0, pd_e} + 33'(run);
    ovf        = is_raw ? (pd_e >= cfg.total) : (sum > {1'b0, cfg.total});
    done       = (left_after == 8'd0) && (sum == {1'b0, cfg.total});
  end

  always_comb begin
    phase_next         = phase_e;
    packet_left_next   = left_e;
    byte_in_pixel_next = bip_e;
    colour_bytes_next  = col_e;
    pixels_done_next   = pd_e;
    res_valid          = 1'b0;
    res                = '0;
    res.first_pixel    = pd_e;

    if (phase_e == PH_HEAD || phase_e == PH_RAW || phase_e == PH_RUN) begin
      if (!cfg.ok) begin
        res_valid  = 1'b1;
        res.status = ST_BAD_CFG;
        phase_next = PH_ERR_CFG;
      end else if (phase_e == PH_HEAD) begin
        if (data_byte < RUN_HEADER_MIN) begin
          packet_left_next = data_byte + 8'd1;
          phase_next       = PH_RAW;
        end else begin
          packet_left_next = data_byte - RUN_BIAS;
          phase_next       = PH_RUN;
        end
        byte_in_pixel_next = '0;
        colour_bytes_next  = '0;
      end else if (!pix_full) begin
        colour_bytes_next  = col_new;
        byte_in_pixel_next = bip_e + 2'd1;
      end else if (ovf) begin
        res_valid  = 1'b1;
        res.status = ST_OVERFLOW;
        phase_next = PH_ERR_OVF;
      end else begin
        res_valid          = 1'b1;
        res.red            = col_new[23:16];
        res.green          = col_new[15:8];
        res.blue           = col_new[7:0];
        res.alpha          = cfg.depth32 ? col_new[31:24] : 8'd0;
        res.run_length     = run;
        res.image_done     = done;
        res.status         = ST_OK;
        packet_left_next   = left_after;
        byte_in_pixel_next = '0;
        colour_bytes_next  = '0;
        pixels_done_next   = sum[31:0];
        if (left_after == 8'd0) begin
          phase_next = done ? PH_DONE : PH_HEAD;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_HEAD;
      packet_left   <= '0;
      byte_in_pixel <= '0;
      colour_bytes  <= '0;
      pixels_done   <= '0;
    end else if (step) begin
      phase         <= phase_next;
      packet_left   <= packet_left_next;
      byte_in_pixel <= byte_in_pixel_next;
      colour_bytes  <= colour_bytes_next;
      pixels_done   <= pixels_done_next;
    end
  end

endmodule

// ===== sv/trle_out_reg.sv =====
`timescale 1ns / 1ps

module trle_out_reg
  import trle_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    load,
  input  logic    load_valid,
  input  result_t load_data,
  output logic    free,
  output logic    result_valid,
  input  logic    result_ready,
  output result_t result
);

  // slot can take a new item when empty or being drained this cycle
  assign free = !result_valid || result_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (load) begin
      result_valid <= load_valid;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load && load_valid) begin
      result <= load_data;
    end
  end

endmodule

// ===== sv/tga_rle_pixel_decoder.sv =====
`timescale 1ns / 1ps
// Latency: a result is valid on the cycle after the byte that completes it is accepted.
// Throughput: one byte per cycle; the result register is the only stall point, and a
//   byte is taken whenever that register is empty or is being read in the same cycle.
// Reset: synchronous, active high; clears the decoder to await a packet header,
//   empties the result register and sets width 1, height 1, 24 bits per pixel.

module tga_rle_pixel_decoder
  import trle_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst,
  // configuration port
  input  logic                    psel,
  input  logic                    penable,
  input  logic                    pwrite,
  input  logic [CfgAddrWidth-1:0] paddr,
  input  logic [CfgDataWidth-1:0] pwdata,
  output logic [CfgDataWidth-1:0] prdata,
  output logic                    pready,
  // compressed byte stream
  input  logic                    data_valid,
  output logic                    data_ready,
  input  logic [7:0]              data_byte,
  input  logic                    frame_start,
  // decoded pixels and runs
  output logic                    result_valid,
  input  logic                    result_ready,
  output logic [7:0]              red,
  output logic [7:0]              green,
  output logic [7:0]              blue,
  output logic [7:0]              alpha,
  output logic [7:0]              run_length,
  output logic [31:0]             first_pixel,
  output logic                    image_done,
  output logic [1:0]              status
);

  cfg_t    cfg;
  logic    step;
  logic    res_valid;
  result_t res;
  result_t result;
  logic    slot_free;

  assign pready = 1'b1;

  // Registers plus the derived pixel total and validity flag; the total is
  // a registered 16x16 product so the byte path only sees an add and compare.
  trle_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .cfg     (cfg)
  );

  // Every accepted byte steps the decoder; header bytes and partial pixel bytes give
  // no result unless the configuration is bad, the last byte of a pixel does.
  assign data_ready = slot_free;
  assign step       = data_valid && data_ready;

  trle_core u_core (
    .clk         (clk),
    .rst         (rst),
    .step        (step),
    .data_byte   (data_byte),
    .frame_start (frame_start),
    .cfg         (cfg),
    .res_valid   (res_valid),
    .res         (res)
  );

  // Result register between decoder and consumer.
  trle_out_reg u_out (
    .clk          (clk),
    .rst          (rst),
    .load         (step),
    .load_valid   (res_valid),
    .load_data    (res),
    .free         (slot_free),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result)
  );

  assign red         = result.red;
  assign green       = result.green;
  assign blue        = result.blue;
  assign alpha       = result.alpha;
  assign run_length  = result.run_length;
  assign first_pixel = result.first_pixel;
  assign image_done  = result.image_done;
  assign status      = result.status;

endmodule

// ===== sim/tb_tga_rle_pixel_decoder.sv =====
`timescale 1ns / 1ps

module tb_tga_rle_pixel_decoder
  import trle_pkg::*;
;

  localparam int unsigned BYTE_TARGET = 2000;  // bytes accepted in the random part
  localparam int unsigned STALL_LIMIT = 2000;  // cycles with no transfer at all
  localparam int unsigned SETTLE      = 3;     // result is registered behind its last byte

  // receiver behaviour, re-chosen every so often
  typedef enum logic [1:0] {
    RX_ALWAYS,
    RX_RANDOM,
    RX_SPARSE
  } rx_mode_t;

  // one row of the directed table: the geometry it needs, the byte, and an
  // optional hand-written expectation that replaces the predicted one
  typedef struct packed {
    logic [15:0] width;
    logic [15:0] height;
    logic [7:0]  bits;
    logic        frame;
    logic [7:0]  data;
    logic        typed;
    result_t     want;
  } step_row_t;

  localparam result_t NO_RUN = '0;
  // red, green, blue, alpha, run_length, first_pixel, image_done, status
  localparam result_t WHOLE_IMAGE_PIXEL = '{8'h33, 8'h22, 8'h11, 8'h00, 8'd1, 32'd0, 1'b1, ST_OK};
  localparam result_t WHITE_RUN_128 = '{8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'd128, 32'd0, 1'b0, ST_OK};
  localparam result_t BAD_CFG_AT_0 = '{8'h00, 8'h00, 8'h00, 8'h00, 8'd0, 32'd0, 1'b0, ST_BAD_CFG};
  localparam result_t OVERFLOW_AT_0 = '{8'h00, 8'h00, 8'h00, 8'h00, 8'd0, 32'd0, 1'b0, ST_OVERFLOW};
  localparam result_t OVERFLOW_AT_1 = '{8'h00, 8'h00, 8'h00, 8'h00, 8'd0, 32'd1, 1'b0, ST_OVERFLOW};

  localparam int DIR_COUNT = 24;
  localparam step_row_t DIR_ROWS [DIR_COUNT] = '{
    // 1x1 image at reset geometry: one raw pixel completes it, BGR becomes RGB
    '{16'd1, 16'd1, BITS_24, 1'b1, 8'h00, 1'b0, NO_RUN},
    '{16'd1, 16'd1, BITS_24, 1'b0, 8'h11, 1'b0, NO_RUN},
    '{16'd1, 16'd1, BITS_24, 1'b0, 8'h22, 1'b0, NO_RUN},
    '{16'd1, 16'd1, BITS_24, 1'b0, 8'h33, 1'b1, WHOLE_IMAGE_PIXEL},
    // image complete: further bytes are swallowed
    '{16'd1, 16'd1, BITS_24, 1'b0, 8'hFF, 1'b0, NO_RUN},
    // zero width, zero height, unsupported depth
    '{16'd0, 16'd1, BITS_24, 1'b1, 8'h00, 1'b1, BAD_CFG_AT_0},
    '{16'd1, 16'd0, BITS_24, 1'b1, 8'h80, 1'b1, BAD_CFG_AT_0},
    '{16'd1, 16'd1, 8'hFF,   1'b1, 8'h7F, 1'b1, BAD_CFG_AT_0},
    // largest image, 32 bpp, longest run of all-ones
    '{16'hFFFF, 16'hFFFF, BITS_32, 1'b1, 8'hFF, 1'b0, NO_RUN},
    '{16'hFFFF, 16'hFFFF, BITS_32, 1'b0, 8'hFF, 1'b0, NO_RUN},
    '{16'hFFFF, 16'hFFFF, BITS_32, 1'b0, 8'hFF, 1'b0, NO_RUN},
    '{16'hFFFF, 16'hFFFF, BITS_32, 1'b0, 8'hFF, 1'b0, NO_RUN},
    '{16'hFFFF, 16'hFFFF, BITS_32, 1'b0, 8'hFF, 1'b1, WHITE_RUN_128},
    // raw packet of two into a 1x1 image: first fits (not done), second overflows
    '{16'd1, 16'd1, BITS_24, 1'b1, 8'h01, 1'b0, NO_RUN},
    '{16'd1, 16'd1, BITS_24, 1'b0, 8'h00, 1'b0, NO_RUN},
    '{16'd1, 16'd1, BITS_24, 1'b0, 8'h80, 1'b0, NO_RUN},
    '{16'd1, 16'd1, BITS_24, 1'b0, 8'hFF, 1'b0, NO_RUN},
    '{16'd1, 16'd1, BITS_24, 1'b0, 8'h01, 1'b0, NO_RUN},
    '{16'd1, 16'd1, BITS_24, 1'b0, 8'h02, 1'b0, NO_RUN},
    '{16'd1, 16'd1, BITS_24, 1'b0, 8'h03, 1'b1, OVERFLOW_AT_1},
    // run of two into a 1x1 image is dropped whole
    '{16'd1, 16'd1, BITS_24, 1'b1, 8'h81, 1'b0, NO_RUN},
    '{16'd1, 16'd1, BITS_24, 1'b0, 8'h10, 1'b0, NO_RUN},
    '{16'd1, 16'd1, BITS_24, 1'b0, 8'h20, 1'b0, NO_RUN},
    '{16'd1, 16'd1, BITS_24, 1'b0, 8'h30, 1'b1, OVERFLOW_AT_0}
  };

  // all inputs known from time zero
  logic                    clk          = 1'b0;
  logic                    rst          = 1'b1;
  logic                    psel         = 1'b0;
  logic                    penable      = 1'b0;
  logic                    pwrite       = 1'b0;
  logic [CfgAddrWidth-1:0] paddr        = '0;
  logic [CfgDataWidth-1:0] pwdata       = '0;
  logic [CfgDataWidth-1:0] prdata;
  logic                    pready;
  logic                    data_valid   = 1'b0;
  logic                    data_ready;
  logic [7:0]              data_byte    = '0;
  logic                    frame_start  = 1'b0;
  logic                    result_valid;
  logic                    result_ready = 1'b0;
  logic [7:0]              red;
  logic [7:0]              green;
  logic [7:0]              blue;
  logic [7:0]              alpha;
  logic [7:0]              run_length;
  logic [31:0]             first_pixel;
  logic                    image_done;
  logic [1:0]              status;

  // predictor copy of the registers and the decoder
  logic [15:0] cfg_width  = WIDTH_RESET;
  logic [15:0] cfg_height = HEIGHT_RESET;
  logic [7:0]  cfg_bits   = BITS_RESET;
  phase_t      dec_phase  = PH_HEAD;
  logic [7:0]  left       = '0;   // pixels still owed by the current packet
  logic [1:0]  byte_idx   = '0;
  logic [31:0] colour     = '0;   // B,G,R,A as they arrive, LSB first
  logic [31:0] pix_count  = '0;

  result_t     runs_due [$];      // decoded runs not yet seen at the output
  int unsigned mismatches = 0;
  int unsigned bytes_sent = 0;    // bytes accepted by the decoder
  int unsigned burst_left = 0;
  int unsigned idle_cycles = 0;
  rx_mode_t    rx_mode = RX_ALWAYS;
  int unsigned rx_hold = 0;

  tga_rle_pixel_decoder dut (
    .clk          (clk),
    .rst          (rst),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready),
    .data_valid   (data_valid),
    .data_ready   (data_ready),
    .data_byte    (data_byte),
    .frame_start  (frame_start),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .red          (red),
    .green        (green),
    .blue         (blue),
    .alpha        (alpha),
    .run_length   (run_length),
    .first_pixel  (first_pixel),
    .image_done   (image_done),
    .status       (status)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  task automatic flag_mismatch(input string msg);
    $display("mismatch @%0t: %s", $realtime, msg);
    mismatches++;
  endtask

  task automatic check_field(input string name, input logic [31:0] got, input logic [31:0] want);
    if (got !== want) begin
      flag_mismatch($sformatf("%s got %0h want %0h", name, got, want));
    end
  endtask

  // an error result carries only the pixel count so far and the code
  function automatic result_t error_run(input logic [1:0] code);
    result_t r;
    r = '0;
    r.first_pixel = pix_count;
    r.status = code;
    return r;
  endfunction

  // advances the predictor by one byte; has_run says whether a result follows
  task automatic decode_byte(input logic frame, input logic [7:0] b,
                             output bit has_run, output result_t run);
    int unsigned nbytes;
    logic [31:0] total;
    logic [7:0]  span;
    logic        done;
    has_run = 1'b0;
    run = '0;
    if (frame) begin
      dec_phase = PH_HEAD;
      left = '0;
      byte_idx = '0;
      colour = '0;
      pix_count = '0;
    end
    if (dec_phase >= PH_DONE) return;
    if (cfg_width == 0 || cfg_height == 0 || (cfg_bits != BITS_24 && cfg_bits != BITS_32)) begin
      run = error_run(ST_BAD_CFG);
      has_run = 1'b1;
      dec_phase = PH_ERR_CFG;
      return;
    end
    nbytes = cfg_bits / 8;
    total = {16'b0, cfg_width} * {16'b0, cfg_height};

    if (dec_phase == PH_HEAD) begin
      if (b < RUN_HEADER_MIN) begin
        left = b + 8'd1;
        dec_phase = PH_RAW;
      end else begin
        left = b - RUN_BIAS;
        dec_phase = PH_RUN;
      end
      byte_idx = '0;
      colour = '0;
      return;
    end

    colour = colour | ({24'b0, b} << (8 * byte_idx));
    // a depth change mid-pixel completes it as soon as it holds enough bytes
    if (byte_idx + 1 < nbytes) begin
      byte_idx = byte_idx + 2'd1;
      return;
    end
    byte_idx = '0;

    if (dec_phase == PH_RAW) begin
      if (pix_count >= total) begin
        run = error_run(ST_OVERFLOW);
        has_run = 1'b1;
        dec_phase = PH_ERR_OVF;
        return;
      end
      span = 8'd1;
      left = left - 8'd1;
    end else begin
      span = left;
      if ({32'b0, pix_count} + span > {32'b0, total}) begin
        run = error_run(ST_OVERFLOW);
        has_run = 1'b1;
        dec_phase = PH_ERR_OVF;
        return;
      end
      left = '0;
    end

    done = (left == 0) && (pix_count + span == total);
    run.red = colour[23:16];
    run.green = colour[15:8];
    run.blue = colour[7:0];
    run.alpha = (nbytes == 4) ? colour[31:24] : 8'h00;
    run.run_length = span;
    run.first_pixel = pix_count;
    run.image_done = done;
    run.status = ST_OK;
    has_run = 1'b1;
    pix_count = pix_count + span;
    colour = '0;
    if (left == 0) dec_phase = done ? PH_DONE : PH_HEAD;
  endtask

  // entered and left at a falling edge; bursts of back-to-back items with
  // random gaps in between
  task automatic send_byte(input logic frame, input logic [7:0] value,
                           input bit typed, input result_t want);
    int unsigned gap;
    bit          has_run;
    result_t     run;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 48);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      if (gap != 0) begin
        data_valid = 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
    burst_left--;
    data_valid = 1'b1;
    frame_start = frame;
    data_byte = value;
    do @(posedge clk); while (!data_ready);
    bytes_sent++;
    decode_byte(frame, value, has_run, run);
    if (typed) runs_due.push_back(want);
    else if (has_run) runs_due.push_back(run);
    @(negedge clk);
  endtask

  // APB write: setup then access phase; predictor follows at the write edge
  task automatic write_reg(input logic [1:0] idx, input logic [31:0] value);
    psel = 1'b1;
    pwrite = 1'b1;
    penable = 1'b0;
    paddr = {idx, 2'b00};
    pwdata = value;
    @(negedge clk);
    penable = 1'b1;
    do @(posedge clk); while (!pready);
    case (idx)
      REG_WIDTH:  cfg_width = value[15:0];
      REG_HEIGHT: cfg_height = value[15:0];
      REG_BITS:   cfg_bits = value[7:0];
      default: ;
    endcase
    @(negedge clk);
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
  endtask

  // only touch the registers once the decoder has gone quiet
  task automatic retune(input logic [15:0] w, input logic [15:0] h, input logic [7:0] bits);
    data_valid = 1'b0;
    while (runs_due.size() != 0) @(negedge clk);
    repeat (SETTLE) @(negedge clk);
    write_reg(REG_WIDTH, {16'b0, w});
    write_reg(REG_HEIGHT, {16'b0, h});
    write_reg(REG_BITS, {24'b0, bits});
  endtask

  // receiver: always ready, coin-toss, or one cycle in eight
  always @(negedge clk) begin
    if (rx_hold == 0) begin
      rx_mode <= rx_mode_t'($urandom_range(0, 2));
      rx_hold <= $urandom_range(16, 200);
    end else begin
      rx_hold <= rx_hold - 1;
    end
    case (rx_mode)
      RX_ALWAYS: result_ready <= 1'b1;
      RX_RANDOM: result_ready <= 1'($urandom_range(0, 1));
      default:   result_ready <= (rx_hold[2:0] == 3'd0);
    endcase
  end

  always @(posedge clk) begin : check_runs
    result_t want;
    if (!rst && result_valid && result_ready) begin
      if (runs_due.size() == 0) begin
        flag_mismatch("result item with nothing expected");
      end else begin
        want = runs_due.pop_front();
        check_field("red", 32'(red), 32'(want.red));
        check_field("green", 32'(green), 32'(want.green));
        check_field("blue", 32'(blue), 32'(want.blue));
        check_field("alpha", 32'(alpha), 32'(want.alpha));
        check_field("run_length", 32'(run_length), 32'(want.run_length));
        check_field("first_pixel", first_pixel, want.first_pixel);
        check_field("image_done", 32'(image_done), 32'(want.image_done));
        check_field("status", 32'(status), 32'(want.status));
      end
    end
  end

  // watchdog: any transfer on any port restarts the count
  always @(posedge clk) begin
    if (rst || (data_valid && data_ready) || (result_valid && result_ready) ||
        (psel && penable && pready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("[tga_rle_pixel_decoder] ERROR");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    step_row_t   row;
    logic [15:0] w;
    logic [15:0] h;
    logic [7:0]  bits;
    int unsigned nb;
    longint      budget;
    int          len;
    int          cap;
    bit          fresh;
    bit          is_run;

    repeat (9) @(negedge clk);
    rst = 1'b0;

    // directed table; geometry changes only between rows once drained
    for (int i = 0; i < DIR_COUNT; i++) begin
      row = DIR_ROWS[i];
      if (row.width != cfg_width || row.height != cfg_height || row.bits != cfg_bits) begin
        retune(row.width, row.height, row.bits);
      end
      send_byte(row.frame, row.data, row.typed, row.want);
    end

    // random part: one geometry per phase, then a mostly well-formed frame
    bytes_sent = 0;
    while (bytes_sent < BYTE_TARGET) begin
      w = 16'($urandom_range(1, 8));
      h = 16'($urandom_range(1, 8));
      bits = $urandom_range(0, 1) ? BITS_32 : BITS_24;
      case ($urandom_range(0, 19))
        0: w = '0;
        1: h = '0;
        2: bits = 8'($urandom_range(0, 255));
        3: w = 16'hFFFF;
        4: h = 16'hFFFF;
        5: begin
          w = 16'hFFFF;
          h = 16'hFFFF;
        end
        6: bits = 8'hFF;
        7: bits = 8'h00;
        default: ;
      endcase
      retune(w, h, bits);

      nb = (bits == BITS_32) ? 4 : 3;
      budget = longint'(w) * longint'(h);
      if (budget == 0) budget = $urandom_range(1, 6);
      else if (budget > 96) budget = $urandom_range(16, 96);
      // now and then carry on the old frame under the new geometry
      fresh = ($urandom_range(0, 7) != 0);

      while (budget > 0) begin
        is_run = 1'($urandom_range(0, 1));
        cap = (budget > 128) ? 128 : int'(budget);
        len = $urandom_range(1, cap);
        if ($urandom_range(0, 24) == 0) len = $urandom_range(1, 128);  // likely overflow
        send_byte(fresh, is_run ? 8'(len + 127) : 8'(len - 1), 1'b0, NO_RUN);
        fresh = 1'b0;
        for (int p = 0; p < (is_run ? 1 : len); p++) begin
          for (int k = 0; k < nb; k++) begin
            // rare restart in the middle of a pixel
            send_byte($urandom_range(0, 299) == 0, 8'($urandom_range(0, 255)), 1'b0, NO_RUN);
          end
        end
        budget -= len;
      end
      // trailing noise after the frame
      repeat ($urandom_range(0, 2)) begin
        send_byte($urandom_range(0, 9) == 0, 8'($urandom_range(0, 255)), 1'b0, NO_RUN);
      end
    end

    data_valid = 1'b0;
    while (runs_due.size() != 0) @(negedge clk);
    repeat (8) @(negedge clk);
    if (mismatches == 0) begin
      $display("[tga_rle_pixel_decoder] OK");
    end else begin
      $display("[tga_rle_pixel_decoder] ERROR");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
sv/trle_pkg.sv
sv/trle_cfg.sv
sv/trle_core.sv
sv/trle_out_reg.sv
sv/tga_rle_pixel_decoder.sv
sim/tb_tga_rle_pixel_decoder.sv
